// ----- rtl/eabm_pkg.sv -----
// Shared constants and types for the EMG activity boundary marker.
// No dependencies; read by the interfaces and by every module of the block.
package eabm_pkg;

    localparam int MAX_HALF_WINDOW = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int THRESH_BITS     = 15;
    localparam int HW_FIELD_BITS   = 5;
    localparam int CFG_DATA_BITS   = 15;
    localparam int CFG_IDX_BITS    = 1;

    // window, doubled window, history distance
    localparam int WIN_BITS    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int OFF_BITS    = WIN_BITS + 1;
    localparam int DIST_BITS   = $clog2(4 * MAX_HALF_WINDOW + 1);
    localparam int HIST_DEPTH  = 4 * MAX_HALF_WINDOW + 1;
    localparam int ADDR_BITS   = DIST_BITS;
    localparam int MEM_DEPTH   = 2 ** ADDR_BITS;

    localparam int COUNT_BITS  = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    // magnitude compare width: holds any sample difference and twice the threshold
    localparam int MAG_BITS = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WINDOW = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_SEL,
        S_RD0,
        S_RD1,
        S_PAIR,
        S_WAIT,
        S_EMIT
    } t_ctrl_state;

    // what a history read beat carries
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_CENTRE,
        TAG_OUTER,
        TAG_PAIR
    } t_rd_tag;

    typedef struct packed {
        logic                 push;
        t_rd_tag              tag;
        logic [DIST_BITS-1:0] dist_a;
        logic [DIST_BITS-1:0] dist_b;
        logic                 clr_hit;
        logic                 emit;
        logic                 judged;
        logic                 last;
        logic                 step_end;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [WIN_BITS-1:0]   win;
        logic                  fin;
        logic                  out_space;
    } t_status;

endpackage

// ----- rtl/eabm_if.sv -----
// Channel interfaces: sample stream in, result stream out, register writes.
// Depends on eabm_pkg for field widths.
interface eabm_smp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [eabm_pkg::SAMPLE_BITS-1:0] sample;
    logic                                 final_sample;

    modport source (output valid, output sample, output final_sample, input ready);
    modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface eabm_res_if;
    logic valid;
    logic ready;
    logic boundary;
    logic last_mark;
    logic short_record;

    modport source (output valid, output boundary, output last_mark, output short_record,
                    input ready);
    modport sink   (input valid, input boundary, input last_mark, input short_record,
                    output ready);
endinterface

interface eabm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [eabm_pkg::CFG_IDX_BITS-1:0]    index;
    logic [eabm_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/eabm_ctrl.sv -----
// Sequencer: walks each sample's judgements and window pair reads.
// Depends on eabm_pkg (state, command and status types).
module eabm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  eabm_pkg::t_status  i_sts,
    output eabm_pkg::t_cmd     o_cmd
);

    eabm_pkg::t_ctrl_state r_state, n_state;
    logic [eabm_pkg::OFF_BITS-1:0] r_off, n_off;
    logic [eabm_pkg::OFF_BITS-1:0] r_m, n_m;
    logic r_judged, n_judged;

    logic [eabm_pkg::OFF_BITS-1:0]   w2;
    logic [eabm_pkg::COUNT_BITS-1:0] off_c, w2_c, gap;
    logic head, tail, skip, more, no_result, last_pair;
    logic [eabm_pkg::OFF_BITS-1:0]   pair_cnt, first_off;
    logic [eabm_pkg::DIST_BITS-1:0]  d_off, d_m, d_w;

    assign w2    = {i_sts.win, 1'b0};
    assign off_c = eabm_pkg::COUNT_BITS'(r_off);
    assign w2_c  = eabm_pkg::COUNT_BITS'(w2);
    assign gap   = i_sts.count - off_c;
    assign head  = gap < w2_c;
    assign tail  = i_sts.fin && (r_off < w2);
    // first and final samples of a record are never judged
    assign skip  = (off_c == i_sts.count) || (r_off == '0);
    assign more  = i_sts.fin && (r_off != '0);
    assign no_result = !i_sts.fin && (i_sts.count < w2_c);
    assign first_off = (i_sts.count < w2_c) ? eabm_pkg::OFF_BITS'(i_sts.count) : w2;

    always_comb begin
        if (tail) begin
            pair_cnt = w2;
        end else if (head) begin
            pair_cnt = (r_off < w2) ? r_off : w2;
        end else begin
            pair_cnt = eabm_pkg::OFF_BITS'(i_sts.win);
        end
    end

    assign last_pair = (r_m == pair_cnt);
    assign d_off = eabm_pkg::DIST_BITS'(r_off);
    assign d_m   = eabm_pkg::DIST_BITS'(r_m);
    assign d_w   = eabm_pkg::DIST_BITS'(i_sts.win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= eabm_pkg::S_IDLE;
            r_off    <= '0;
            r_m      <= eabm_pkg::OFF_BITS'(1);
            r_judged <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_off    <= n_off;
            r_m      <= n_m;
            r_judged <= n_judged;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            eabm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = eabm_pkg::S_PLAN;
            end
            eabm_pkg::S_PLAN: begin
                n_state = no_result ? eabm_pkg::S_IDLE : eabm_pkg::S_SEL;
            end
            eabm_pkg::S_SEL: begin
                n_state = skip ? eabm_pkg::S_EMIT : eabm_pkg::S_RD0;
            end
            eabm_pkg::S_RD0:  n_state = eabm_pkg::S_RD1;
            eabm_pkg::S_RD1:  n_state = eabm_pkg::S_PAIR;
            eabm_pkg::S_PAIR: begin
                if (last_pair) n_state = eabm_pkg::S_WAIT;
            end
            eabm_pkg::S_WAIT: n_state = eabm_pkg::S_EMIT;
            eabm_pkg::S_EMIT: begin
                if (i_sts.out_space) n_state = more ? eabm_pkg::S_SEL : eabm_pkg::S_IDLE;
            end
            default: n_state = eabm_pkg::S_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        n_off    = r_off;
        n_m      = r_m;
        n_judged = r_judged;
        case (r_state)
            eabm_pkg::S_PLAN: n_off = i_sts.fin ? first_off : w2;
            eabm_pkg::S_SEL:  n_judged = !skip;
            eabm_pkg::S_RD1:  n_m = eabm_pkg::OFF_BITS'(1);
            eabm_pkg::S_PAIR: begin
                if (!last_pair) n_m = r_m + eabm_pkg::OFF_BITS'(1);
            end
            eabm_pkg::S_EMIT: begin
                if (i_sts.out_space && more) n_off = r_off - eabm_pkg::OFF_BITS'(1);
            end
            default: ;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.tag  = eabm_pkg::TAG_NONE;
        case (r_state)
            eabm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.push = i_in_valid;
            end
            eabm_pkg::S_PLAN: o_cmd.step_end = no_result;
            eabm_pkg::S_RD0: begin
                o_cmd.tag     = eabm_pkg::TAG_CENTRE;
                o_cmd.dist_a  = d_off;
                o_cmd.dist_b  = d_off + eabm_pkg::DIST_BITS'(1);
                o_cmd.clr_hit = 1'b1;
            end
            eabm_pkg::S_RD1: begin
                o_cmd.tag    = eabm_pkg::TAG_OUTER;
                o_cmd.dist_a = d_off - eabm_pkg::DIST_BITS'(1);
            end
            eabm_pkg::S_PAIR: begin
                o_cmd.tag = eabm_pkg::TAG_PAIR;
                if (tail) begin
                    o_cmd.dist_a = d_off;
                    o_cmd.dist_b = d_off + d_m;
                end else if (head) begin
                    o_cmd.dist_a = d_off;
                    o_cmd.dist_b = d_off - d_m;
                end else begin
                    // symmetric pair about the centre sample
                    o_cmd.dist_a = d_off + d_m - eabm_pkg::DIST_BITS'(1) - d_w;
                    o_cmd.dist_b = d_off + d_w + eabm_pkg::DIST_BITS'(1) - d_m;
                end
            end
            eabm_pkg::S_EMIT: begin
                if (i_sts.out_space) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.judged   = r_judged;
                    o_cmd.last     = i_sts.fin && (r_off == '0);
                    o_cmd.step_end = !more;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eabm_pkg::S_EMIT && !i_sts.out_space)
        |=> (r_state == eabm_pkg::S_EMIT && $stable(r_off)))
        else $error("emit stall lost its place");
    a_off_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != eabm_pkg::S_IDLE && r_state != eabm_pkg::S_PLAN) |-> (r_off <= w2))
        else $error("offset beyond doubled window");
    a_pair_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eabm_pkg::S_PAIR) |-> (r_m != '0 && r_m <= pair_cnt))
        else $error("pair index out of range");
`endif

endmodule

// ----- rtl/eabm_dp.sv -----
// Datapath: config registers, sample history memory, judge accumulators,
// activity flag and result register. Depends on eabm_pkg and eabm_if.
module eabm_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic signed [eabm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                    i_final_sample,
    eabm_cfg_if.sink                                i_cfg,
    eabm_res_if.source                              o_res,
    input  eabm_pkg::t_cmd                          i_cmd,
    output eabm_pkg::t_status                       o_sts
);

    logic [eabm_pkg::THRESH_BITS-1:0]   r_threshold;
    logic [eabm_pkg::HW_FIELD_BITS-1:0] r_half_window;
    logic [eabm_pkg::WIN_BITS-1:0]      win;

    logic signed [eabm_pkg::SAMPLE_BITS-1:0] r_hist [eabm_pkg::MEM_DEPTH];
    logic [eabm_pkg::ADDR_BITS-1:0] r_wp, wr_addr, rd_addr_a, rd_addr_b;
    logic signed [eabm_pkg::SAMPLE_BITS-1:0] r_rd_a, r_rd_b, data_a, data_b;
    logic r_va, r_vb;
    eabm_pkg::t_rd_tag r_tag;

    logic signed [eabm_pkg::SAMPLE_BITS-1:0] r_x, r_pin, r_pout;
    logic r_hit;

    logic [eabm_pkg::COUNT_BITS-1:0] r_count, short_lim;
    logic r_fin, r_prev_active;
    logic r_out_valid, r_boundary, r_last, r_short;

    logic signed [eabm_pkg::MAG_BITS-1:0] pdiff, x_ext;
    logic [eabm_pkg::MAG_BITS-1:0] pmag, xmag, thr_e, thr2_e;
    logic pair_hit, big, mono, active, mark, out_space;

    // ---- configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_half_window <= eabm_pkg::HW_FIELD_BITS'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                eabm_pkg::CFG_THRESHOLD:
                    r_threshold <= i_cfg.data[eabm_pkg::THRESH_BITS-1:0];
                eabm_pkg::CFG_HALF_WINDOW:
                    r_half_window <= i_cfg.data[eabm_pkg::HW_FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_half_window == '0) begin
            win = eabm_pkg::WIN_BITS'(1);
        end else if (int'(r_half_window) > eabm_pkg::MAX_HALF_WINDOW) begin
            win = eabm_pkg::WIN_BITS'(eabm_pkg::MAX_HALF_WINDOW);
        end else begin
            win = eabm_pkg::WIN_BITS'(r_half_window);
        end
    end

    // ---- history: circular buffer, newest at r_wp, read by distance
    assign wr_addr   = r_wp + eabm_pkg::ADDR_BITS'(1);
    assign rd_addr_a = r_wp - i_cmd.dist_a;
    assign rd_addr_b = r_wp - i_cmd.dist_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_hist[wr_addr] <= i_sample;
        r_rd_a <= r_hist[rd_addr_a];
        r_rd_b <= r_hist[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_tag <= eabm_pkg::TAG_NONE;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_cmd.push) r_wp <= wr_addr;
            r_tag <= i_cmd.tag;
            // entries older than the record start read as zero
            r_va  <= i_cmd.dist_a <= r_count;
            r_vb  <= i_cmd.dist_b <= r_count;
        end
    end

    assign data_a = r_va ? r_rd_a : '0;
    assign data_b = r_vb ? r_rd_b : '0;

    // ---- judge
    assign thr_e  = eabm_pkg::MAG_BITS'(r_threshold);
    assign thr2_e = eabm_pkg::MAG_BITS'({r_threshold, 1'b0});

    assign pdiff    = eabm_pkg::MAG_BITS'(data_a) - eabm_pkg::MAG_BITS'(data_b);
    assign pmag     = pdiff[eabm_pkg::MAG_BITS-1] ? eabm_pkg::MAG_BITS'(-pdiff)
                                                  : eabm_pkg::MAG_BITS'(pdiff);
    assign pair_hit = pmag > thr2_e;

    always_ff @(posedge i_clk) begin
        case (r_tag)
            eabm_pkg::TAG_CENTRE: begin
                r_x   <= data_a;
                r_pin <= data_b;
            end
            eabm_pkg::TAG_OUTER: r_pout <= data_a;
            eabm_pkg::TAG_PAIR: begin
                if (pair_hit) r_hit <= 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.clr_hit) r_hit <= 1'b0;
    end

    assign x_ext  = eabm_pkg::MAG_BITS'(r_x);
    assign xmag   = x_ext[eabm_pkg::MAG_BITS-1] ? eabm_pkg::MAG_BITS'(-x_ext)
                                                : eabm_pkg::MAG_BITS'(x_ext);
    assign big    = xmag > thr_e;
    // strictly rising or falling through the centre sample
    assign mono   = ((r_x > r_pin) && (r_pout > r_x)) || ((r_x < r_pin) && (r_pout < r_x));
    assign active = big || mono || ((r_x != '0) && r_hit);
    assign mark   = i_cmd.judged && (active != r_prev_active);

    // ---- record state
    assign short_lim = eabm_pkg::COUNT_BITS'({win, 2'b00}) + eabm_pkg::COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin         <= 1'b0;
            r_count       <= '0;
            r_prev_active <= 1'b0;
        end else begin
            if (i_cmd.push) r_fin <= i_final_sample;
            if (i_cmd.step_end && r_fin) begin
                r_count       <= '0;
                r_prev_active <= 1'b0;
            end else begin
                if (i_cmd.step_end && r_count != eabm_pkg::COUNT_LIMIT) begin
                    r_count <= r_count + eabm_pkg::COUNT_BITS'(1);
                end
                if (i_cmd.emit && i_cmd.judged) r_prev_active <= active;
            end
        end
    end

    // ---- result register
    assign out_space = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_boundary <= mark;
            r_last     <= i_cmd.last;
            r_short    <= r_fin && (r_count < short_lim);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.boundary     = r_boundary;
    assign o_res.last_mark    = r_last;
    assign o_res.short_record = r_short;

    assign o_sts.count     = r_count;
    assign o_sts.win       = win;
    assign o_sts.fin       = r_fin;
    assign o_sts.out_space = out_space;

endmodule

// ----- rtl/emg_activity_boundary_marker.sv -----
// EMG activity boundary marker, top level. Each sample passes accept and plan, and one that
// yields no result takes just those. A judged result adds select, centre and outer reads,
// P pair compares (P = up to 2w under edge rules or w in the middle, one pair a cycle over
// the two-read-port history memory), wait and emit; an unjudged one adds select and emit.
// A final sample emits up to 2w+1 results. Synchronous active-low reset clears control and
// state registers but not data; history is hidden by the fill count, so no clearing pass.
module emg_activity_boundary_marker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eabm_smp_if.sink    i_smp,
    eabm_res_if.source  o_res,
    eabm_cfg_if.sink    i_cfg
);

    eabm_pkg::t_cmd    cmd;
    eabm_pkg::t_status sts;
    logic              in_ready;

    assign i_smp.ready = in_ready;

    eabm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    eabm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (i_smp.sample),
        .i_final_sample (i_smp.final_sample),
        .i_cfg          (i_cfg),
        .o_res          (o_res),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
